// ----- design/rro_pkg.sv -----
// Package for the rectangle overlap test core: widths, stage payload types
// and small arithmetic helpers. No dependencies.
`default_nettype none

package rro_pkg;

   localparam int CoordW    = 32;  // signed Q16.16 centre difference
   localparam int HalfW     = 31;  // unsigned Q15.16 half extent
   localparam int TrigW     = 16;  // signed Q2.14 cosine / sine
   localparam int DotW      = 32;  // axis dot axis, 16x16 product
   localparam int DotSumW   = 33;  // sum of two axis products, signed
   localparam int ProdW     = 48;  // trig times coordinate
   localparam int ProjW     = 49;  // sum of two such products, signed
   localparam int ProjMagW  = 48;  // magnitude of a projection
   localparam int LhsShift  = 14;
   localparam int OwnShift  = 28;
   localparam int LhsW      = ProjMagW + LhsShift;  // 62
   localparam int OwnW      = HalfW + OwnShift;     // 59
   localparam int CrossW    = HalfW + DotW;         // 63
   localparam int SumW      = 64;
   localparam int DiffW     = 63;
   localparam int NumAxes   = 4;
   localparam int NumStages = 5;

   // Axis order in all per-axis arrays
   localparam int AxisA1 = 0;
   localparam int AxisA2 = 1;
   localparam int AxisB1 = 2;
   localparam int AxisB2 = 3;

   typedef struct packed {
      logic signed [CoordW-1:0] delta_x;
      logic signed [CoordW-1:0] delta_y;
      logic [HalfW-1:0]         a_half_w;
      logic [HalfW-1:0]         a_half_h;
      logic signed [TrigW-1:0]  a_cos;
      logic signed [TrigW-1:0]  a_sin;
      logic [HalfW-1:0]         b_half_w;
      logic [HalfW-1:0]         b_half_h;
      logic signed [TrigW-1:0]  b_cos;
      logic signed [TrigW-1:0]  b_sin;
      logic                     use_oriented;
   } req_item_type;

   // after the product stage
   typedef struct packed {
      logic                     oriented;
      logic [CoordW-1:0]        dx_mag;
      logic [CoordW-1:0]        dy_mag;
      logic [CoordW-1:0]        w_sum;
      logic [CoordW-1:0]        h_sum;
      logic signed [DotW-1:0]   cc;
      logic signed [DotW-1:0]   ss;
      logic signed [DotW-1:0]   sc;
      logic signed [DotW-1:0]   cs;
      logic signed [ProdW-1:0]  acdx;
      logic signed [ProdW-1:0]  asdy;
      logic signed [ProdW-1:0]  acdy;
      logic signed [ProdW-1:0]  asdx;
      logic signed [ProdW-1:0]  bcdx;
      logic signed [ProdW-1:0]  bsdy;
      logic signed [ProdW-1:0]  bcdy;
      logic signed [ProdW-1:0]  bsdx;
      logic [HalfW-1:0]         wa;
      logic [HalfW-1:0]         ha;
      logic [HalfW-1:0]         wb;
      logic [HalfW-1:0]         hb;
   } s1_type;

   // after the projection stage
   typedef struct packed {
      logic                             oriented;
      logic                             aa_hit;
      logic [DotW-1:0]                  p;
      logic [DotW-1:0]                  q;
      logic [NumAxes-1:0][ProjMagW-1:0] proj_mag;
      logic [HalfW-1:0]                 wa;
      logic [HalfW-1:0]                 ha;
      logic [HalfW-1:0]                 wb;
      logic [HalfW-1:0]                 hb;
   } s2_type;

   // after the radius stage
   typedef struct packed {
      logic                           oriented;
      logic                           aa_hit;
      logic [NumAxes-1:0][LhsW-1:0]   lhs;
      logic [NumAxes-1:0][OwnW-1:0]   own;
      logic [NumAxes-1:0][CrossW-1:0] cross1;
      logic [NumAxes-1:0][CrossW-1:0] cross2;
   } s3_type;

   // after the partial sum stage
   typedef struct packed {
      logic                          oriented;
      logic                          aa_hit;
      logic [NumAxes-1:0][DiffW-1:0] diff;
      logic [NumAxes-1:0][SumW-1:0]  csum;
   } s4_type;

   typedef struct packed {
      logic s4;
      logic s5;
   } decide_en_type;

   function automatic logic [DotW-1:0] mag_dot(input logic signed [DotSumW-1:0] v);
      return v[DotSumW-1] ? DotW'(-v) : DotW'(v);
   endfunction

   function automatic logic [ProjMagW-1:0] mag_proj(input logic signed [ProjW-1:0] v);
      return v[ProjW-1] ? ProjMagW'(-v) : ProjMagW'(v);
   endfunction

   function automatic logic [CoordW-1:0] mag_coord(input logic signed [CoordW-1:0] v);
      return v[CoordW-1] ? CoordW'(-v) : CoordW'(v);
   endfunction

endpackage

`default_nettype wire

// ----- design/rro_req_if.sv -----
// Request channel of the rectangle overlap test core: valid/ready plus one
// rectangle pair. Depends on rro_pkg.
`default_nettype none

interface rro_req_if
   import rro_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] delta_x;
   logic signed [CoordW-1:0] delta_y;
   logic [HalfW-1:0]         a_half_w;
   logic [HalfW-1:0]         a_half_h;
   logic signed [TrigW-1:0]  a_cos;
   logic signed [TrigW-1:0]  a_sin;
   logic [HalfW-1:0]         b_half_w;
   logic [HalfW-1:0]         b_half_h;
   logic signed [TrigW-1:0]  b_cos;
   logic signed [TrigW-1:0]  b_sin;
   logic                     use_oriented;

   modport source (
      output valid, delta_x, delta_y, a_half_w, a_half_h, a_cos, a_sin,
             b_half_w, b_half_h, b_cos, b_sin, use_oriented,
      input  ready
   );

   modport sink (
      input  valid, delta_x, delta_y, a_half_w, a_half_h, a_cos, a_sin,
             b_half_w, b_half_h, b_cos, b_sin, use_oriented,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/rro_rsp_if.sv -----
// Response channel of the rectangle overlap test core: valid/ready plus the
// overlap flag. No dependencies.
`default_nettype none

interface rro_rsp_if;
   logic valid;
   logic ready;
   logic overlap;

   modport source (output valid, overlap, input ready);
   modport sink (input valid, overlap, output ready);
endinterface

`default_nettype wire

// ----- design/rect_rect_overlap_test_core.sv -----
// Top level of the 2D rectangle overlap test: five-stage pipeline, oriented
// (separating axis) or axis-aligned mode per item.
// Depends on rro_pkg, rro_req_if, rro_rsp_if, rro_prod, rro_proj, rro_radius, rro_decide.
//
//   channel    dir  handshake            payload
//   req_chan   in   valid / ready        rectangle pair, mode bit
//   rsp_chan   out  valid / ready        overlap
//
// One item per cycle sustained while rsp_chan.ready stays high; an accepted item
// shows up as a valid response after passing five register stages (product, projection,
// radius, partial sum, compare).
// Reset clears the stage valid bits only; data registers are not reset.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stalled response holds only the stages behind it.
`default_nettype none

module rect_rect_overlap_test_core
   import rro_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rro_req_if.sink   req_chan,
   rro_rsp_if.source rsp_chan
);

   logic [NumStages-1:0] valid_ff, valid_in;
   logic [NumStages-1:0] adv;
   req_item_type         item;
   s1_type               s1;
   s2_type               s2;
   s3_type               s3;
   decide_en_type        dec_en;
   logic                 overlap;

   always_comb begin
      adv[NumStages-1] = !valid_ff[NumStages-1] || rsp_chan.ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_chan.valid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      item.delta_x      = req_chan.delta_x;
      item.delta_y      = req_chan.delta_y;
      item.a_half_w     = req_chan.a_half_w;
      item.a_half_h     = req_chan.a_half_h;
      item.a_cos        = req_chan.a_cos;
      item.a_sin        = req_chan.a_sin;
      item.b_half_w     = req_chan.b_half_w;
      item.b_half_h     = req_chan.b_half_h;
      item.b_cos        = req_chan.b_cos;
      item.b_sin        = req_chan.b_sin;
      item.use_oriented = req_chan.use_oriented;
   end

   assign dec_en.s4 = adv[3];
   assign dec_en.s5 = adv[4];

   rro_prod u_prod (
      .clock (clock),
      .en    (adv[0]),
      .item  (item),
      .s1    (s1)
   );

   rro_proj u_proj (
      .clock (clock),
      .en    (adv[1]),
      .s1    (s1),
      .s2    (s2)
   );

   rro_radius u_radius (
      .clock (clock),
      .en    (adv[2]),
      .s2    (s2),
      .s3    (s3)
   );

   rro_decide u_decide (
      .clock   (clock),
      .en      (dec_en),
      .s3      (s3),
      .overlap (overlap)
   );

   assign req_chan.ready   = adv[0];
   assign rsp_chan.valid   = valid_ff[NumStages-1];
   assign rsp_chan.overlap = overlap;

endmodule

`default_nettype wire

// ----- design/rro_prod.sv -----
// Stage 1: all trig products, plus magnitudes and extent sums for the
// axis-aligned test. Depends on rro_pkg.
`default_nettype none

module rro_prod
   import rro_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         en,
   input  wire req_item_type item,
   output s1_type            s1
);

   s1_type s1_ff, s1_in;

   always_comb begin
      s1_in.oriented = item.use_oriented;
      s1_in.dx_mag   = mag_coord(item.delta_x);
      s1_in.dy_mag   = mag_coord(item.delta_y);
      s1_in.w_sum    = CoordW'(item.a_half_w) + CoordW'(item.b_half_w);
      s1_in.h_sum    = CoordW'(item.a_half_h) + CoordW'(item.b_half_h);
      s1_in.cc       = item.a_cos * item.b_cos;
      s1_in.ss       = item.a_sin * item.b_sin;
      s1_in.sc       = item.a_sin * item.b_cos;
      s1_in.cs       = item.a_cos * item.b_sin;
      s1_in.acdx     = item.a_cos * item.delta_x;
      s1_in.asdy     = item.a_sin * item.delta_y;
      s1_in.acdy     = item.a_cos * item.delta_y;
      s1_in.asdx     = item.a_sin * item.delta_x;
      s1_in.bcdx     = item.b_cos * item.delta_x;
      s1_in.bsdy     = item.b_sin * item.delta_y;
      s1_in.bcdy     = item.b_cos * item.delta_y;
      s1_in.bsdx     = item.b_sin * item.delta_x;
      s1_in.wa       = item.a_half_w;
      s1_in.ha       = item.a_half_h;
      s1_in.wb       = item.b_half_w;
      s1_in.hb       = item.b_half_h;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

`default_nettype wire

// ----- design/rro_proj.sv -----
// Stage 2: projections of the centre difference on the four axes, the
// axis-to-axis dot products and the axis-aligned verdict. Depends on rro_pkg.
`default_nettype none

module rro_proj
   import rro_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   en,
   input  wire s1_type s1,
   output s2_type      s2
);

   s2_type s2_ff, s2_in;
   logic signed [DotSumW-1:0] p_sum, q_sum;
   logic signed [ProjW-1:0]   pa1, pa2, pb1, pb2;

   always_comb begin
      // P = A1.B1 = A2.B2, Q = A1.B2 = -(A2.B1)
      p_sum = DotSumW'(s1.cc) + DotSumW'(s1.ss);
      q_sum = DotSumW'(s1.sc) - DotSumW'(s1.cs);
      pa1   = ProjW'(s1.acdx) + ProjW'(s1.asdy);
      pa2   = ProjW'(s1.acdy) - ProjW'(s1.asdx);
      pb1   = ProjW'(s1.bcdx) + ProjW'(s1.bsdy);
      pb2   = ProjW'(s1.bcdy) - ProjW'(s1.bsdx);

      s2_in.oriented         = s1.oriented;
      s2_in.aa_hit           = (s1.dx_mag <= s1.w_sum) && (s1.dy_mag <= s1.h_sum);
      s2_in.p                = mag_dot(p_sum);
      s2_in.q                = mag_dot(q_sum);
      s2_in.proj_mag[AxisA1] = mag_proj(pa1);
      s2_in.proj_mag[AxisA2] = mag_proj(pa2);
      s2_in.proj_mag[AxisB1] = mag_proj(pb1);
      s2_in.proj_mag[AxisB2] = mag_proj(pb2);
      s2_in.wa               = s1.wa;
      s2_in.ha               = s1.ha;
      s2_in.wb               = s1.wb;
      s2_in.hb               = s1.hb;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

`default_nettype wire

// ----- design/rro_radius.sv -----
// Stage 3: projected radii of both rectangles on each axis, all at scale
// 2^28, and the scaled projected distances. Depends on rro_pkg.
`default_nettype none

module rro_radius
   import rro_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   en,
   input  wire s2_type s2,
   output s3_type      s3
);

   s3_type s3_ff, s3_in;

   always_comb begin
      s3_in.oriented = s2.oriented;
      s3_in.aa_hit   = s2.aa_hit;
      for (int i = 0; i < NumAxes; i++) begin
         s3_in.lhs[i] = {s2.proj_mag[i], LhsShift'(0)};
      end
      s3_in.own[AxisA1]    = {s2.wa, OwnShift'(0)};
      s3_in.own[AxisA2]    = {s2.ha, OwnShift'(0)};
      s3_in.own[AxisB1]    = {s2.wb, OwnShift'(0)};
      s3_in.own[AxisB2]    = {s2.hb, OwnShift'(0)};
      s3_in.cross1[AxisA1] = s2.wb * s2.p;
      s3_in.cross2[AxisA1] = s2.hb * s2.q;
      s3_in.cross1[AxisA2] = s2.wb * s2.q;
      s3_in.cross2[AxisA2] = s2.hb * s2.p;
      s3_in.cross1[AxisB1] = s2.wa * s2.p;
      s3_in.cross2[AxisB1] = s2.ha * s2.q;
      s3_in.cross1[AxisB2] = s2.wa * s2.q;
      s3_in.cross2[AxisB2] = s2.ha * s2.p;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

`default_nettype wire

// ----- design/rro_decide.sv -----
// Stages 4 and 5: per-axis separation compare split over two registers,
// then the final overlap flag. Depends on rro_pkg.
`default_nettype none

module rro_decide
   import rro_pkg::*;
(
   input  wire logic          clock,
   input  wire decide_en_type en,
   input  wire s3_type        s3,
   output logic               overlap
);

   s4_type             s4_ff, s4_in;
   logic               overlap_ff, overlap_in;
   logic [NumAxes-1:0] sep;

   // |proj| > r_own + r_c1 + r_c2  <=>  (|proj| - r_own) > (r_c1 + r_c2)
   always_comb begin
      s4_in.oriented = s3.oriented;
      s4_in.aa_hit   = s3.aa_hit;
      for (int i = 0; i < NumAxes; i++) begin
         s4_in.diff[i] = DiffW'(s3.lhs[i]) - DiffW'(s3.own[i]);
         s4_in.csum[i] = SumW'(s3.cross1[i]) + SumW'(s3.cross2[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NumAxes; i++) begin
         sep[i] = !s4_ff.diff[i][DiffW-1] && (SumW'(s4_ff.diff[i]) > s4_ff.csum[i]);
      end
      overlap_in = s4_ff.oriented ? !(|sep) : s4_ff.aa_hit;
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         s4_ff <= s4_in;
      end
      if (en.s5) begin
         overlap_ff <= overlap_in;
      end
   end

   assign overlap = overlap_ff;

endmodule

`default_nettype wire
